/* rtl/lrs_pkg.sv */
package lrs_pkg;

	localparam int DataWidth = 32;
	// Quotient bits kept by the divider: the scaled magnitude saturates at 2^33.
	localparam int DivSteps = 33;
	// s1, s2, s3, the divider steps, the result stage and the output register.
	localparam int PipeDepth = DivSteps + 5;
	localparam int CountWidth = $clog2(PipeDepth + 1);

	typedef enum logic [2:0] {
		REG_IN_LOW       = 3'd0,
		REG_IN_HIGH      = 3'd1,
		REG_OUT_LOW      = 3'd2,
		REG_OUT_HIGH     = 3'd3,
		REG_CLAMP_ENABLE = 3'd4
	} reg_idx_t;

	localparam logic [DataWidth-1:0] InLowReset   = 32'sd0;
	localparam logic [DataWidth-1:0] InHighReset  = 32'sd1;
	localparam logic [DataWidth-1:0] OutLowReset  = 32'sd0;
	localparam logic [DataWidth-1:0] OutHighReset = 32'sd1;
	localparam logic                 ClampReset   = 1'b1;

	// One restoring-division step state. rem < den unless ovf is set; num holds dividend bits still to shift in.
	typedef struct packed {
		logic [32:0] rem;
		logic [32:0] num;
		logic [32:0] quo;
		logic [32:0] den;
		logic        neg;
		logic        deg;
		logic        ovf;
	} div_t;

	function automatic div_t div_step(input div_t cur);
		logic [33:0] trial;
		logic [33:0] diff;
		logic        ge;
		div_t        nxt;
		trial = {cur.rem, cur.num[32]};
		diff = trial - {1'b0, cur.den};
		ge = (trial >= {1'b0, cur.den});
		nxt = cur;
		nxt.rem = ge ? diff[32:0] : trial[32:0];
		nxt.num = {cur.num[31:0], 1'b0};
		nxt.quo = {cur.quo[31:0], ge};
		return nxt;
	endfunction

endpackage

/* rtl/lrs_if.sv */
interface lrs_sample_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [lrs_pkg::DataWidth-1:0] sample;

	modport source(output valid, output sample, input ready);
	modport sink(input valid, input sample, output ready);
endinterface

interface lrs_scaled_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [lrs_pkg::DataWidth-1:0] scaled;

	modport source(output valid, output scaled, input ready);
	modport sink(input valid, input scaled, output ready);
endinterface

/* rtl/linear_range_scaler_top.sv */
// A sample word accepted at the input passes through 38 register stages, the output
// register included, before its scaled word can be taken.
// Throughput: one word per cycle; the whole pipeline advances together and holds on a stall.
// Most of those stages are the 33-step restoring divider, one quotient bit per pipeline stage.
// Reset (arst_n low, asynchronous) empties the pipeline and loads the registers with
// in_low 0, in_high 1, out_low 0, out_high 1, clamp_enable 1.
module linear_range_scaler_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  logic [2:0]  wr_index,
	input  logic [31:0] wr_data,
	lrs_sample_if.sink  samples,
	lrs_scaled_if.source results
);

	localparam int Steps = lrs_pkg::DivSteps;

	logic [31:0] in_low_q, in_high_q, out_low_q, out_high_q;
	logic        clamp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_low_q   <= lrs_pkg::InLowReset;
			in_high_q  <= lrs_pkg::InHighReset;
			out_low_q  <= lrs_pkg::OutLowReset;
			out_high_q <= lrs_pkg::OutHighReset;
			clamp_q    <= lrs_pkg::ClampReset;
		end else if (wr_en) begin
			unique case (lrs_pkg::reg_idx_t'(wr_index))
				lrs_pkg::REG_IN_LOW:       in_low_q   <= wr_data;
				lrs_pkg::REG_IN_HIGH:      in_high_q  <= wr_data;
				lrs_pkg::REG_OUT_LOW:      out_low_q  <= wr_data;
				lrs_pkg::REG_OUT_HIGH:     out_high_q <= wr_data;
				lrs_pkg::REG_CLAMP_ENABLE: clamp_q    <= wr_data[0];
				default: ;
			endcase
		end
	end

	function automatic logic [31:0] mag33(input logic [32:0] v);
		logic [32:0] a;
		a = v[32] ? 33'(-v) : v;
		return a[31:0];
	endfunction

	logic advance;
	logic out_vld_q;
	logic [31:0] scaled_q;

	assign advance = !out_vld_q || results.ready;
	assign samples.ready = advance;

	// Stage 1: spans and magnitudes
	logic [32:0] dx, ds, dn;
	logic [31:0] sample_bits;

	assign sample_bits = samples.sample;
	assign dx = {sample_bits[31], sample_bits} - {in_low_q[31], in_low_q};
	assign ds = {out_high_q[31], out_high_q} - {out_low_q[31], out_low_q};
	assign dn = {in_high_q[31], in_high_q} - {in_low_q[31], in_low_q};

	logic        vld_s1;
	logic [31:0] mdx_s1, mds_s1, mdn_s1;
	logic        neg_s1, deg_s1;

	// Stage 2: product
	logic        vld_s2;
	logic [63:0] prod_s2;
	logic [31:0] mdn_s2;
	logic        neg_s2, deg_s2;

	// Stage 3: floor((2*A + d) / (2*d)) folds the round-half-up to nearest into one division
	logic [65:0] dividend;
	logic [32:0] den;
	lrs_pkg::div_t div_init;

	assign dividend = {1'b0, prod_s2, 1'b0} + {34'd0, mdn_s2};
	assign den = {mdn_s2, 1'b0};

	always_comb begin
		div_init.rem = dividend[65:33];
		div_init.num = dividend[32:0];
		div_init.quo = '0;
		div_init.den = den;
		div_init.neg = neg_s2;
		div_init.deg = deg_s2;
		// quotient of 2^33 or more saturates: result lies outside any 32-bit span
		div_init.ovf = (dividend[65:33] >= den);
	end

	lrs_pkg::div_t div_s [0:Steps];
	logic          div_vld_s [0:Steps];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			div_vld_s[0] <= 1'b0;
		end else if (advance) begin
			vld_s1 <= samples.valid;
			vld_s2 <= vld_s1;
			div_vld_s[0] <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			mdx_s1  <= mag33(dx);
			mds_s1  <= mag33(ds);
			mdn_s1  <= mag33(dn);
			neg_s1  <= dx[32] ^ ds[32] ^ dn[32];
			deg_s1  <= (dn == 33'd0);
			prod_s2 <= mdx_s1 * mds_s1;
			mdn_s2  <= mdn_s1;
			neg_s2  <= neg_s1;
			deg_s2  <= deg_s1;
			div_s[0] <= div_init;
		end
	end

	for (genvar k = 0; k < Steps; k++) begin : g_div
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_vld_s[k+1] <= 1'b0;
			end else if (advance) begin
				div_vld_s[k+1] <= div_vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (advance) begin
				div_s[k+1] <= lrs_pkg::div_step(div_s[k]);
			end
		end
	end

	// Stage 4: offset from out_low
	lrs_pkg::div_t      dv;
	logic [33:0]        mag;
	logic signed [34:0] ol35, m35, res_next;
	logic               vld_s4;
	logic signed [34:0] res_s4;

	assign dv = div_s[Steps];
	assign mag = dv.ovf ? 34'h2_0000_0000 : {1'b0, dv.quo};
	assign ol35 = {{3{out_low_q[31]}}, out_low_q};
	assign m35 = {1'b0, mag};

	always_comb begin
		if (dv.deg) begin
			res_next = ol35;
		end else if (dv.neg) begin
			res_next = ol35 - m35;
		end else begin
			res_next = ol35 + m35;
		end
	end

	// Stage 5: clamp to span or saturate to 32 bits
	logic signed [34:0] oh35, lo35, hi35, sat_lo, sat_hi;
	logic signed [34:0] clipped;

	assign oh35 = {{3{out_high_q[31]}}, out_high_q};
	assign lo35 = (ol35 < oh35) ? ol35 : oh35;
	assign hi35 = (ol35 < oh35) ? oh35 : ol35;
	assign sat_lo = clamp_q ? lo35 : -35'sd2147483648;
	assign sat_hi = clamp_q ? hi35 : 35'sd2147483647;

	always_comb begin
		if (res_s4 < sat_lo) begin
			clipped = sat_lo;
		end else if (res_s4 > sat_hi) begin
			clipped = sat_hi;
		end else begin
			clipped = res_s4;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4    <= 1'b0;
			out_vld_q <= 1'b0;
		end else if (advance) begin
			vld_s4    <= div_vld_s[Steps];
			out_vld_q <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s4   <= res_next;
			scaled_q <= clipped[31:0];
		end
	end

	assign results.valid = out_vld_q;
	assign results.scaled = scaled_q;

endmodule

/* rtl/lrs_checker.sv */
module lrs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] out_scaled
);

	localparam int Cw = lrs_pkg::CountWidth;

	logic [Cw-1:0] inflight_q;
	logic          in_acc, out_acc;

	assign in_acc = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else begin
			inflight_q <= inflight_q + Cw'(in_acc) - Cw'(out_acc);
		end
	end

	// stalled word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_scaled))
		else $error("output word changed while stalled");

	// every output word was accepted earlier
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> inflight_q != '0)
		else $error("output word with nothing in flight");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= Cw'(lrs_pkg::PipeDepth))
		else $error("more words in flight than pipeline stages");

	// an empty output register never blocks the input
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with output register empty");

endmodule

bind linear_range_scaler_top lrs_checker u_lrs_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (samples.valid),
	.in_ready   (samples.ready),
	.out_valid  (results.valid),
	.out_ready  (results.ready),
	.out_scaled (results.scaled)
);
